// ===== hdl/page_stage_header_parser_defines.svh =====
// Assertion macros used by the page stage header parser top level.
`ifndef PAGE_STAGE_HEADER_PARSER_DEFINES_SVH
`define PAGE_STAGE_HEADER_PARSER_DEFINES_SVH

// Concurrent assertion on the rising clock edge, off while reset is held.
`define PSH_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Concurrent assertion on the rising clock edge that also holds during reset.
`define PSH_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== hdl/psh_pkg.sv =====
// Types and constants shared by the page stage header parser modules.
package psh_pkg;

  localparam int unsigned PSH_FIFO_DEPTH = 4;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned VALUE_W = 63;
  localparam int unsigned STAGE_W = 8;
  localparam int unsigned WORD_W  = 64;
  localparam int unsigned META_W  = 32;
  localparam int unsigned FBC_W   = 4;

  localparam logic [FBC_W-1:0] HDR_FIELD_LEN   = 4'd8;
  localparam logic [FBC_W-1:0] STAGE_FIELD_LEN = 4'd4;

  typedef enum logic [3:0] {
    PH_HDR,
    PH_REP,
    PH_DEF,
    PH_VAL,
    PH_COUNT,
    PH_ENC,
    PH_MLEN,
    PH_META,
    PH_TAIL
  } psh_phase_e;

  typedef enum logic [3:0] {
    K_REP_LEN     = 4'd0,
    K_DEF_LEN     = 4'd1,
    K_VAL_LEN     = 4'd2,
    K_STAGE_COUNT = 4'd3,
    K_ENCODING    = 4'd4,
    K_META_LEN    = 4'd5,
    K_META_BYTE   = 4'd6,
    K_OK          = 4'd7,
    K_ERROR       = 4'd8
  } psh_kind_e;

  typedef enum logic [3:0] {
    E_SHORT       = 4'd0,
    E_MAGIC       = 4'd1,
    E_VERSION     = 4'd2,
    E_TRUNC_I64   = 4'd3,
    E_NEGATIVE    = 4'd4,
    E_NO_COUNT    = 4'd5,
    E_TRUNC_STAGE = 4'd6,
    E_META_OOB    = 4'd7,
    E_EXTRA       = 4'd8
  } psh_err_e;

  typedef enum logic [0:0] {
    REG_MAGIC   = 1'b0,
    REG_VERSION = 1'b1
  } psh_reg_e;

  typedef struct packed {
    psh_kind_e            kind;
    logic [VALUE_W-1:0]   value;
    logic [STAGE_W-1:0]   stage;
    psh_err_e             err;
    logic                 last;
  } psh_result_t;

endpackage

// ===== hdl/psh_step.sv =====
// Per-item header parsing: frame state registers and the decode of one item.
module psh_step (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  accept_i,
  input  logic [7:0]            byte_value_i,
  input  logic                  frame_end_i,
  input  logic [31:0]           exp_magic_i,
  input  logic [7:0]            exp_version_i,
  output logic [1:0]            res_cnt_o,
  output psh_pkg::psh_result_t  res0_o,
  output psh_pkg::psh_result_t  res1_o
);
  import psh_pkg::*;

  psh_phase_e           phase_q, phase_d;
  logic [FBC_W-1:0]     fbc_q, fbc_d;
  logic [WORD_W-1:0]    aw_q, aw_d;
  logic [STAGE_W-1:0]   sr_q, sr_d;
  logic [STAGE_W-1:0]   cs_q, cs_d;
  logic [META_W-1:0]    mr_q, mr_d;
  logic [2:0]           pend_q, pend_d;
  logic                 disc_q, disc_d;

  logic [WORD_W-1:0]    aw_acc;
  logic [FBC_W-1:0]     fbc_inc;
  logic                 hdr_done;
  logic                 word_done;
  logic                 magic_ok;
  logic                 ver_ok;
  logic [2:0]           len_bit;
  psh_kind_e            len_kind;
  logic [2:0]           pend_new;
  logic [META_W-1:0]    mlen;
  logic                 mlen_zero;
  logic [META_W-1:0]    mr_dec;
  logic                 meta_last;
  logic [STAGE_W-1:0]   sr_dec;
  logic [STAGE_W-1:0]   bnd_sr;
  logic                 fe;

  logic                 field_v;
  psh_result_t          field;
  logic                 fin_v;
  logic                 fin_ok;
  psh_err_e             fin_code;
  logic                 restart;
  logic                 discard_set;
  psh_result_t          fin;

  assign fe        = frame_end_i;
  assign aw_acc    = aw_q | (WORD_W'(byte_value_i) << {fbc_q[2:0], 3'b000});
  assign fbc_inc   = fbc_q + FBC_W'(1);
  assign hdr_done  = (fbc_inc >= HDR_FIELD_LEN);
  assign word_done = (fbc_inc >= STAGE_FIELD_LEN);
  assign magic_ok  = (aw_acc[31:0] == exp_magic_i);
  assign ver_ok    = (aw_acc[39:32] == exp_version_i);
  assign mlen      = aw_acc[META_W-1:0];
  assign mlen_zero = (mlen == '0);
  assign mr_dec    = mr_q - META_W'(1);
  assign meta_last = (mr_dec == '0);
  assign sr_dec    = sr_q - STAGE_W'(1);
  assign bnd_sr    = (phase_q == PH_COUNT) ? byte_value_i : sr_dec;
  assign pend_new  = pend_q | (aw_acc[WORD_W-1] ? len_bit : 3'b000);

  always_comb begin
    case (phase_q)
      PH_REP: begin
        len_bit  = 3'b001;
        len_kind = K_REP_LEN;
      end
      PH_DEF: begin
        len_bit  = 3'b010;
        len_kind = K_DEF_LEN;
      end
      default: begin
        len_bit  = 3'b100;
        len_kind = K_VAL_LEN;
      end
    endcase
  end

  // Decode of the item against the current phase: which results it causes
  // and whether the frame restarts or falls into discard.
  always_comb begin
    field_v     = 1'b0;
    field       = '0;
    fin_v       = 1'b0;
    fin_ok      = 1'b0;
    fin_code    = E_SHORT;
    restart     = 1'b0;
    discard_set = 1'b0;
    if (disc_q) begin
      restart = fe;
    end else begin
      unique case (phase_q) inside
        PH_HDR: begin
          if (!hdr_done) begin
            if (fe) begin
              fin_v    = 1'b1;
              fin_code = E_SHORT;
            end
          end else if (!magic_ok) begin
            fin_v    = 1'b1;
            fin_code = E_MAGIC;
          end else if (!ver_ok) begin
            fin_v    = 1'b1;
            fin_code = E_VERSION;
          end else if (fe) begin
            fin_v    = 1'b1;
            fin_code = E_TRUNC_I64;
          end
        end
        PH_REP, PH_DEF, PH_VAL: begin
          if (!hdr_done) begin
            if (fe) begin
              fin_v    = 1'b1;
              fin_code = E_TRUNC_I64;
            end
          end else begin
            field_v     = 1'b1;
            field.kind  = len_kind;
            field.value = aw_acc[VALUE_W-1:0];
            if (phase_q != PH_VAL) begin
              if (fe) begin
                fin_v    = 1'b1;
                fin_code = E_TRUNC_I64;
              end
            end else if (pend_new != 3'b000) begin
              fin_v    = 1'b1;
              fin_code = E_NEGATIVE;
            end else if (fe) begin
              fin_v    = 1'b1;
              fin_code = E_NO_COUNT;
            end
          end
        end
        PH_COUNT: begin
          field_v     = 1'b1;
          field.kind  = K_STAGE_COUNT;
          field.value = VALUE_W'(byte_value_i);
          if (bnd_sr == '0) begin
            if (fe) begin
              fin_v  = 1'b1;
              fin_ok = 1'b1;
            end
          end else if (fe) begin
            fin_v    = 1'b1;
            fin_code = E_TRUNC_STAGE;
          end
        end
        PH_ENC: begin
          if (!word_done) begin
            if (fe) begin
              fin_v    = 1'b1;
              fin_code = E_TRUNC_STAGE;
            end
          end else begin
            field_v     = 1'b1;
            field.kind  = K_ENCODING;
            field.value = VALUE_W'(aw_acc[31:0]);
            field.stage = cs_q;
            if (fe) begin
              fin_v    = 1'b1;
              fin_code = E_TRUNC_STAGE;
            end
          end
        end
        PH_MLEN: begin
          if (!word_done) begin
            if (fe) begin
              fin_v    = 1'b1;
              fin_code = E_TRUNC_STAGE;
            end
          end else begin
            field_v     = 1'b1;
            field.kind  = K_META_LEN;
            field.value = VALUE_W'(mlen);
            field.stage = cs_q;
            if (mlen_zero) begin
              if (bnd_sr == '0) begin
                if (fe) begin
                  fin_v  = 1'b1;
                  fin_ok = 1'b1;
                end
              end else if (fe) begin
                fin_v    = 1'b1;
                fin_code = E_TRUNC_STAGE;
              end
            end else if (fe) begin
              fin_v    = 1'b1;
              fin_code = E_META_OOB;
            end
          end
        end
        PH_META: begin
          field_v     = 1'b1;
          field.kind  = K_META_BYTE;
          field.value = VALUE_W'(byte_value_i);
          field.stage = cs_q;
          if (meta_last) begin
            if (bnd_sr == '0) begin
              if (fe) begin
                fin_v  = 1'b1;
                fin_ok = 1'b1;
              end
            end else if (fe) begin
              fin_v    = 1'b1;
              fin_code = E_TRUNC_STAGE;
            end
          end else if (fe) begin
            fin_v    = 1'b1;
            fin_code = E_META_OOB;
          end
        end
        PH_TAIL: begin
          fin_v    = 1'b1;
          fin_code = E_EXTRA;
        end
        default: begin
          restart = 1'b1;
        end
      endcase
      if (fin_v) begin
        if (fin_ok) begin
          restart = 1'b1;
        end else begin
          restart     = fe;
          discard_set = !fe;
        end
      end
    end
  end

  // Next state of the frame registers.
  always_comb begin
    phase_d = phase_q;
    fbc_d   = fbc_q;
    aw_d    = aw_q;
    sr_d    = sr_q;
    cs_d    = cs_q;
    mr_d    = mr_q;
    pend_d  = pend_q;
    disc_d  = disc_q;
    if (accept_i) begin
      if (!disc_q) begin
        unique case (phase_q) inside
          PH_HDR: begin
            aw_d  = aw_acc;
            fbc_d = fbc_inc;
            if (hdr_done && magic_ok && ver_ok) begin
              phase_d = PH_REP;
              fbc_d   = '0;
              aw_d    = '0;
            end
          end
          PH_REP, PH_DEF, PH_VAL: begin
            aw_d  = aw_acc;
            fbc_d = fbc_inc;
            if (hdr_done) begin
              pend_d = pend_new;
              fbc_d  = '0;
              aw_d   = '0;
              if (phase_q == PH_REP) begin
                phase_d = PH_DEF;
              end else if (phase_q == PH_DEF) begin
                phase_d = PH_VAL;
              end else begin
                phase_d = PH_COUNT;
              end
            end
          end
          PH_COUNT: begin
            sr_d    = byte_value_i;
            cs_d    = '0;
            fbc_d   = '0;
            aw_d    = '0;
            phase_d = (byte_value_i == '0) ? PH_TAIL : PH_ENC;
          end
          PH_ENC: begin
            aw_d  = aw_acc;
            fbc_d = fbc_inc;
            if (word_done) begin
              phase_d = PH_MLEN;
              fbc_d   = '0;
              aw_d    = '0;
            end
          end
          PH_MLEN: begin
            aw_d  = aw_acc;
            fbc_d = fbc_inc;
            if (word_done) begin
              fbc_d = '0;
              aw_d  = '0;
              if (mlen_zero) begin
                sr_d    = sr_dec;
                cs_d    = cs_q + STAGE_W'(1);
                phase_d = (sr_dec == '0) ? PH_TAIL : PH_ENC;
              end else begin
                mr_d    = mlen;
                phase_d = PH_META;
              end
            end
          end
          PH_META: begin
            mr_d = mr_dec;
            if (meta_last) begin
              sr_d    = sr_dec;
              cs_d    = cs_q + STAGE_W'(1);
              fbc_d   = '0;
              aw_d    = '0;
              phase_d = (sr_dec == '0) ? PH_TAIL : PH_ENC;
            end
          end
          PH_TAIL: begin
            phase_d = PH_TAIL;
          end
          default: begin
            phase_d = PH_HDR;
          end
        endcase
      end
      if (discard_set) begin
        disc_d = 1'b1;
      end
      if (restart) begin
        phase_d = PH_HDR;
        fbc_d   = '0;
        aw_d    = '0;
        sr_d    = '0;
        cs_d    = '0;
        mr_d    = '0;
        pend_d  = '0;
        disc_d  = 1'b0;
      end
    end
  end

  // Result slots for the item: a field result first, the frame outcome last.
  always_comb begin
    fin       = '0;
    fin.kind  = fin_ok ? K_OK : K_ERROR;
    fin.err   = fin_ok ? E_SHORT : fin_code;
    fin.last  = 1'b1;
    res1_o    = fin;
    res0_o    = field_v ? field : fin;
    res0_o.last = !(field_v && fin_v);
    if (accept_i) begin
      res_cnt_o = 2'(field_v) + 2'(fin_v);
    end else begin
      res_cnt_o = 2'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HDR;
      fbc_q   <= '0;
      aw_q    <= '0;
      sr_q    <= '0;
      cs_q    <= '0;
      mr_q    <= '0;
      pend_q  <= '0;
      disc_q  <= 1'b0;
    end else begin
      phase_q <= phase_d;
      fbc_q   <= fbc_d;
      aw_q    <= aw_d;
      sr_q    <= sr_d;
      cs_q    <= cs_d;
      mr_q    <= mr_d;
      pend_q  <= pend_d;
      disc_q  <= disc_d;
    end
  end

endmodule

// ===== hdl/psh_fifo.sv =====
// Result queue that takes up to two results per cycle and hands out one.
module psh_fifo #(
  parameter int unsigned Depth = psh_pkg::PSH_FIFO_DEPTH
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [1:0]                   push_cnt_i,
  input  psh_pkg::psh_result_t         push0_i,
  input  psh_pkg::psh_result_t         push1_i,
  input  logic                         pop_i,
  output psh_pkg::psh_result_t         head_o,
  output logic [$clog2(Depth+1)-1:0]   level_o
);
  import psh_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  psh_result_t         mem_q [Depth];
  logic [PtrW-1:0]     wp_q, wp_d;
  logic [PtrW-1:0]     rp_q, rp_d;
  logic [CntW-1:0]     level_q, level_d;
  logic [PtrW-1:0]     wp1;
  logic [PtrW-1:0]     wp2;

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    return (p == PtrW'(Depth - 1)) ? '0 : p + PtrW'(1);
  endfunction

  assign wp1 = ptr_inc(wp_q);
  assign wp2 = ptr_inc(wp1);

  always_comb begin
    case (push_cnt_i)
      2'd1:    wp_d = wp1;
      2'd2:    wp_d = wp2;
      default: wp_d = wp_q;
    endcase
    rp_d    = pop_i ? ptr_inc(rp_q) : rp_q;
    level_d = level_q + CntW'(push_cnt_i) - CntW'(pop_i);
  end

  assign head_o  = mem_q[rp_q];
  assign level_o = level_q;

  always_ff @(posedge clk_i) begin
    if (push_cnt_i != 2'd0) begin
      mem_q[wp_q] <= push0_i;
    end
    if (push_cnt_i == 2'd2) begin
      mem_q[wp1] <= push1_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q    <= '0;
      rp_q    <= '0;
      level_q <= '0;
    end else begin
      wp_q    <= wp_d;
      rp_q    <= rp_d;
      level_q <= level_d;
    end
  end

endmodule

// ===== hdl/page_stage_header_parser.sv =====
// Top level of the streaming page stage header parser.
//
//   channel   direction  handshake                  payload
//   input     in         in_valid_i / in_stall_o    byte_value_i, frame_end_i
//   result    out        out_valid_o / out_stall_i  kind_o, value_o, stage_number_o,
//                                                   error_code_o, last_of_run_o
//   config    in         APB psel/penable/pready    paddr, pwdata, prdata
//
// An item is decoded in the cycle it is accepted, and its results enter the result
// queue at that clock edge, so a result leaves from the registered queue head.
// One item per cycle is taken while results drain at the same pace; an item that
// closes a field and the frame in one go yields two results, which both leave
// through the single queue read port. The input stalls while the queue has fewer
// than two free entries. Reset returns the parser to the start of a frame, clears
// both registers to zero and empties the queue.
`include "page_stage_header_parser_defines.svh"

module page_stage_header_parser #(
  parameter int unsigned FifoDepth = psh_pkg::PSH_FIFO_DEPTH
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_stall_o,
  input  logic [7:0]   byte_value_i,
  input  logic         frame_end_i,
  output logic         out_valid_o,
  input  logic         out_stall_i,
  output logic [3:0]   kind_o,
  output logic [62:0]  value_o,
  output logic [7:0]   stage_number_o,
  output logic [3:0]   error_code_o,
  output logic         last_of_run_o,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);
  import psh_pkg::*;

  localparam int unsigned CntW = $clog2(FifoDepth + 1);

  logic [31:0]       magic_q;
  logic [7:0]        version_q;
  logic              cfg_wr;
  psh_reg_e          reg_sel;
  logic              in_acc;
  logic              out_pop;
  logic [1:0]        res_cnt;
  psh_result_t       res0;
  psh_result_t       res1;
  psh_result_t       head;
  logic [CntW-1:0]   level;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign reg_sel = psh_reg_e'(paddr[2]);

  always_comb begin
    unique case (reg_sel)
      REG_MAGIC:   prdata = magic_q;
      REG_VERSION: prdata = {24'd0, version_q};
      default:     prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      magic_q   <= '0;
      version_q <= '0;
    end else if (cfg_wr) begin
      if (reg_sel == REG_MAGIC) begin
        magic_q <= pwdata;
      end else begin
        version_q <= pwdata[7:0];
      end
    end
  end

  assign in_stall_o = (level > CntW'(FifoDepth - 2));
  assign in_acc     = in_valid_i && !in_stall_o;

  psh_step u_step (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (in_acc),
    .byte_value_i  (byte_value_i),
    .frame_end_i   (frame_end_i),
    .exp_magic_i   (magic_q),
    .exp_version_i (version_q),
    .res_cnt_o     (res_cnt),
    .res0_o        (res0),
    .res1_o        (res1)
  );

  psh_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_cnt_i (res_cnt),
    .push0_i    (res0),
    .push1_i    (res1),
    .pop_i      (out_pop),
    .head_o     (head),
    .level_o    (level)
  );

  assign out_valid_o    = (level != '0);
  assign out_pop        = out_valid_o && !out_stall_i;
  assign kind_o         = head.kind;
  assign value_o        = head.value;
  assign stage_number_o = head.stage;
  assign error_code_o   = head.err;
  assign last_of_run_o  = head.last;

  `PSH_ASSERT(a_level_bound, level <= CntW'(FifoDepth), "result queue overflow")
  `PSH_ASSERT(a_result_appears, in_acc && res_cnt != 2'd0 |=> out_valid_o, "result lost")
  `PSH_ASSERT(a_error_clean, out_valid_o && kind_o == K_ERROR |-> value_o == '0 && stage_number_o == '0, "error result carries payload")
  `PSH_ASSERT(a_code_only_on_error, out_valid_o && kind_o != K_ERROR |-> error_code_o == E_SHORT, "error code on a non-error result")

endmodule
